>>> hw/rtl/dna_window_composition_counter_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the window composition counter
// Each macro checks one implication at the rising edge of aclk. The check is
// off while aresetn is low. Synthesis builds get empty bodies.
// ----------------------------------------------------------------------------
`ifndef DNA_WINDOW_COMPOSITION_COUNTER_UNIT_MACROS_SVH
`define DNA_WINDOW_COMPOSITION_COUNTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define DWCC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error("dwcc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DWCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error("dwcc assertion failed");

`else

`define DWCC_ASSERT_NOW(label, ante, cons)
`define DWCC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> hw/rtl/dwcc_pkg.sv
// ----------------------------------------------------------------------------
// dwcc_pkg
// Shared widths, symbol codes and register indexes of the window composition
// counter.
// ----------------------------------------------------------------------------
`default_nettype none

package dwcc_pkg;

    localparam int SYM_W     = 8;
    localparam int CFG_W     = 11;
    localparam int CNT_W     = 11;
    localparam int MATCH_W   = 32;
    localparam int NUM_BASES = 4;
    localparam int CODE_W    = 3;
    localparam int IDX_W     = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [SYM_W-1:0] CHAR_A = 8'h41;
    localparam logic [SYM_W-1:0] CHAR_C = 8'h43;
    localparam logic [SYM_W-1:0] CHAR_G = 8'h47;
    localparam logic [SYM_W-1:0] CHAR_T = 8'h54;

    // Code stored in the delay line for each symbol.
    typedef enum logic [CODE_W-1:0] {
        CODE_OTHER,
        CODE_A,
        CODE_C,
        CODE_G,
        CODE_T
    } base_code_t;

    localparam base_code_t BASE_CODES [NUM_BASES] = '{CODE_A, CODE_C, CODE_G, CODE_T};

    typedef enum logic [IDX_W-1:0] {
        REG_WINDOW_LEN,
        REG_MIN_A,
        REG_MIN_C,
        REG_MIN_G,
        REG_MIN_T
    } reg_index_t;

    // One counter update: the symbol entering and, if any, the symbol leaving.
    typedef struct packed {
        logic       en;
        base_code_t add_code;
        logic       drop;
        base_code_t drop_code;
    } cnt_upd_t;

    function automatic base_code_t code_of(input logic [SYM_W-1:0] ch);
        base_code_t code;
        case (ch)
            CHAR_A:  code = CODE_A;
            CHAR_C:  code = CODE_C;
            CHAR_G:  code = CODE_G;
            CHAR_T:  code = CODE_T;
            default: code = CODE_OTHER;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/dwcc_count_bank.sv
// ----------------------------------------------------------------------------
// dwcc_count_bank
// Four saturating base counters and the check of every count against its
// configured minimum.
// ----------------------------------------------------------------------------
`default_nettype none

module dwcc_count_bank import dwcc_pkg::*; (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire cnt_upd_t                            upd,
    input  wire logic [NUM_BASES-1:0][CFG_W-1:0]     min_base,
    output logic                                     all_met
);

    logic [NUM_BASES-1:0][CNT_W-1:0] count_reg;
    logic [NUM_BASES-1:0][CNT_W-1:0] count_next;
    logic [NUM_BASES-1:0]            met;

    // The leaving symbol is removed before the entering one is added, each
    // step clamped at its end of the range.
    always_comb begin
        for (int i = 0; i < NUM_BASES; i++) begin
            count_next[i] = count_reg[i];
            if (upd.drop && (upd.drop_code == BASE_CODES[i]) && (count_next[i] != '0)) begin
                count_next[i] = count_next[i] - CNT_W'(1);
            end
            if ((upd.add_code == BASE_CODES[i]) && (count_next[i] != CNT_MAX)) begin
                count_next[i] = count_next[i] + CNT_W'(1);
            end
            met[i] = (count_reg[i] >= min_base[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (upd.en) begin
            count_reg <= count_next;
        end
    end

    assign all_met = &met;

endmodule

`default_nettype wire

>>> hw/rtl/dna_window_composition_counter_unit.sv
// ----------------------------------------------------------------------------
// dna_window_composition_counter_unit
// Sliding window over a stream of sequence characters. Counts A, C, G and T
// in the last window_len symbols and flags windows that meet all four
// configured minimums, with a saturating total of such windows.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Ports                          Contents
//   -------  ---------  -----------------------------  ---------------------------
//   input    in         s_valid/s_ready, s_*           one character and end mark
//   result   out        m_valid/m_ready, m_*           window flags and running total
//   config   in         cfg_wr_en, cfg_addr, cfg_data  window length and minimums
//
// The block takes one beat per clock cycle while the result channel is not
// stalled, and returns one result beat for each input beat. A taken beat
// moves from the delay-line read and stage 1 registers through the counters
// and stage 2 registers to the output register. A stalled result freezes the
// whole pipeline; input is taken again in the same cycle the result goes out.
// Reset is synchronous and clears the counters, the fill level and the write
// slot at once; the delay line needs no clearing because the fill level keeps
// every read that is used inside written entries.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dna_window_composition_counter_unit_macros.svh"

module dna_window_composition_counter_unit import dwcc_pkg::*; #(
    parameter int MAX_WINDOW = 1024
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               cfg_wr_en,
    input  wire logic [IDX_W-1:0]   cfg_addr,
    input  wire logic [CFG_W-1:0]   cfg_data,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [SYM_W-1:0]   s_symbol,
    input  wire logic               s_last_symbol,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_window_full,
    output logic                    m_window_ok,
    output logic [MATCH_W-1:0]      m_match_total,
    output logic                    m_final_res
);

    localparam int ADDR_W = $clog2(MAX_WINDOW);
    localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W  = (WIN_W > CFG_W) ? WIN_W : CFG_W;

    localparam logic [CMP_W-1:0]  WIN_MAX   = CMP_W'(MAX_WINDOW);
    localparam logic [ADDR_W:0]   SLOT_SPAN = (ADDR_W + 1)'(MAX_WINDOW);
    localparam logic [ADDR_W-1:0] SLOT_LAST = ADDR_W'(MAX_WINDOW - 1);
    localparam logic [WIN_W-1:0]  FILL_MAX  = WIN_W'(MAX_WINDOW);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]                window_len_reg;
    logic [NUM_BASES-1:0][CFG_W-1:0] min_base_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_len_reg <= CFG_W'(1);
            min_base_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (reg_index_t'(cfg_addr))
                REG_WINDOW_LEN: window_len_reg  <= cfg_data;
                REG_MIN_A:      min_base_reg[0] <= cfg_data;
                REG_MIN_C:      min_base_reg[1] <= cfg_data;
                REG_MIN_G:      min_base_reg[2] <= cfg_data;
                REG_MIN_T:      min_base_reg[3] <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A length of zero behaves as one; anything above the delay line's
    // depth is clamped to the depth.
    logic [CMP_W-1:0] win_len_ext;
    logic [CMP_W-1:0] win_eff;

    assign win_len_ext = CMP_W'(window_len_reg);
    assign win_eff     = (win_len_ext == '0)     ? CMP_W'(1) :
                         (win_len_ext > WIN_MAX) ? WIN_MAX   : win_len_ext;

    // ------------------------------------------------------------------
    // Pipeline advance. Every stage moves together whenever the output
    // register is empty or being emptied.
    // ------------------------------------------------------------------
    logic adv;
    logic accept;
    logic m_valid_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign accept  = s_valid && adv;

    // ------------------------------------------------------------------
    // Stage 0: slot bookkeeping and delay-line access
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] slot_reg;
    logic [ADDR_W-1:0] slot_next;
    logic [WIN_W-1:0]  fill_reg;
    logic [WIN_W-1:0]  fill_next;
    logic              drop;
    logic              full;
    logic [ADDR_W:0]   old_diff;
    logic [ADDR_W:0]   old_wrapped;
    logic [ADDR_W-1:0] old_slot;
    base_code_t        in_code;

    assign in_code = code_of(s_symbol);

    // The leaving symbol sits one window behind the write slot, modulo the
    // depth. The difference is negative at most by one depth.
    assign old_diff    = {1'b0, slot_reg} - (ADDR_W + 1)'(win_eff);
    assign old_wrapped = old_diff + SLOT_SPAN;
    assign old_slot    = old_diff[ADDR_W] ? old_wrapped[ADDR_W-1:0] : old_diff[ADDR_W-1:0];

    assign drop      = (CMP_W'(fill_reg) >= win_eff);
    assign fill_next = (fill_reg != FILL_MAX) ? fill_reg + WIN_W'(1) : fill_reg;
    assign full      = (CMP_W'(fill_next) >= win_eff);
    assign slot_next = (slot_reg == SLOT_LAST) ? '0 : slot_reg + ADDR_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
            fill_reg <= '0;
        end else if (accept) begin
            slot_reg <= slot_next;
            fill_reg <= fill_next;
        end
    end

    // Delay line, read before write. When the window spans the whole depth
    // the old slot equals the write slot and the read returns the old code.
    // With a window of one, the slot written by one beat is read by the next
    // beat, after the write has landed.
    logic [CODE_W-1:0] delay_mem [MAX_WINDOW];
    logic [CODE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            rd_data_reg <= delay_mem[old_slot];
        end
        if (accept) begin
            delay_mem[slot_reg] <= in_code;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: counter update
    // ------------------------------------------------------------------
    logic       v1_reg;
    base_code_t code1_reg;
    logic       drop1_reg;
    logic       full1_reg;
    logic       last1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            code1_reg <= in_code;
            drop1_reg <= drop;
            full1_reg <= full;
            last1_reg <= s_last_symbol;
        end
    end

    cnt_upd_t cnt_upd;
    logic     all_met;

    assign cnt_upd.en        = adv && v1_reg;
    assign cnt_upd.add_code  = code1_reg;
    assign cnt_upd.drop      = drop1_reg;
    assign cnt_upd.drop_code = base_code_t'(rd_data_reg);

    dwcc_count_bank u_count_bank (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .upd      (cnt_upd),
        .min_base (min_base_reg),
        .all_met  (all_met)
    );

    // ------------------------------------------------------------------
    // Stage 2: minimum check against the updated counts, running total
    // ------------------------------------------------------------------
    logic v2_reg;
    logic full2_reg;
    logic last2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            full2_reg <= full1_reg;
            last2_reg <= last1_reg;
        end
    end

    logic               ok;
    logic [MATCH_W-1:0] matches_reg;
    logic [MATCH_W-1:0] matches_next;

    assign ok           = full2_reg && all_met;
    assign matches_next = (ok && (matches_reg != '1)) ? matches_reg + MATCH_W'(1) : matches_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            matches_reg <= '0;
        end else if (adv && v2_reg) begin
            matches_reg <= matches_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic               m_window_full_reg;
    logic               m_window_ok_reg;
    logic [MATCH_W-1:0] m_match_total_reg;
    logic               m_final_res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && v2_reg) begin
            m_window_full_reg <= full2_reg;
            m_window_ok_reg   <= ok;
            m_match_total_reg <= matches_next;
            m_final_res_reg   <= last2_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_window_full = m_window_full_reg;
    assign m_window_ok   = m_window_ok_reg;
    assign m_match_total = m_match_total_reg;
    assign m_final_res   = m_final_res_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A window can only qualify once it is full.
    `DWCC_ASSERT_NOW(a_ok_needs_full, m_valid_reg && m_window_ok_reg, m_window_full_reg)

    // The running total never goes backward.
    `DWCC_ASSERT_NEXT(a_total_monotone, aresetn, matches_reg >= $past(matches_reg))

    // An accepted input beat always enters the counter update stage.
    `DWCC_ASSERT_NEXT(a_accept_enters_pipe, s_valid && s_ready, v1_reg)

endmodule

`default_nettype wire
